[rtl/ercd_pkg.sv]
package ercd_pkg;

	localparam int FIELD_W    = 16;
	localparam int DIGIT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CATCH_UP_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSED_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE   = 2'd2;

	localparam logic [FIELD_W-1:0] LENGTH_RESET = 16'd2000;

	typedef struct packed {
		logic [FIELD_W-1:0] time_step;
		logic [FIELD_W-1:0] observed_count;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] shown_count;
		logic [DIGIT_W-1:0] digit_thousands;
		logic [DIGIT_W-1:0] digit_hundreds;
		logic [DIGIT_W-1:0] digit_tens;
		logic [DIGIT_W-1:0] digit_units;
		logic               blank_thousands;
		logic               blank_hundreds;
		logic               blank_tens;
		logic               catching_up;
	} out_item_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] thousands;
		logic [DIGIT_W-1:0] hundreds;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
	} bcd_digits_t;

	typedef struct packed {
		logic done;
		logic inexact;
	} muldiv_status_t;

endpackage

[rtl/ercd_muldiv.sv]
// floor(delta * (len^2 - rem^2) / len^2) with remainder flag.
// One squarer, one shared add/subtract datapath over a product/remainder register.
module ercd_muldiv #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [TIME_BITS-1:0]        len_in,
	input  logic [TIME_BITS-1:0]        rem_in,
	input  logic [COUNT_BITS-1:0]       delta,
	output logic [COUNT_BITS-1:0]       quotient,
	output ercd_pkg::muldiv_status_t    status
);
	import ercd_pkg::*;

	localparam int SQ_W  = 2 * TIME_BITS;
	localparam int P_W   = COUNT_BITS + SQ_W;
	localparam int CNT_W = $clog2(COUNT_BITS);

	typedef enum logic [2:0] {U_IDLE, U_DEN, U_RR, U_NUM, U_MUL, U_DIV, U_DONE} ustate_t;

	ustate_t               state_q;
	logic [TIME_BITS-1:0]  len_q;
	logic [TIME_BITS-1:0]  rem_q;
	logic [SQ_W-1:0]       den_q;
	logic [SQ_W-1:0]       num_q;
	logic [P_W-1:0]        prod_q;
	logic [CNT_W-1:0]      cnt_q;

	logic [TIME_BITS-1:0]  sq_op;
	logic [SQ_W-1:0]       sq;
	logic [SQ_W-1:0]       hi;
	logic [COUNT_BITS-1:0] lo;
	logic                  mul_mode;
	logic [SQ_W:0]         acc_a;
	logic [SQ_W:0]         acc_b;
	logic [SQ_W+1:0]       acc_sum;
	logic                  ge;

	assign sq_op = (state_q == U_DEN) ? len_q : rem_q;
	assign sq    = SQ_W'(sq_op) * SQ_W'(sq_op);

	assign hi = prod_q[P_W-1:COUNT_BITS];
	assign lo = prod_q[COUNT_BITS-1:0];

	// multiply: hi += num when lsb set; divide: trial subtract of den
	assign mul_mode = (state_q == U_MUL);
	assign acc_a    = mul_mode ? {1'b0, hi} : {hi, lo[COUNT_BITS-1]};
	assign acc_b    = mul_mode ? (lo[0] ? {1'b0, num_q} : '0) : ~{1'b0, den_q};
	assign acc_sum  = {1'b0, acc_a} + {1'b0, acc_b} + {{(SQ_W+1){1'b0}}, ~mul_mode};
	assign ge       = acc_sum[SQ_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			len_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			num_q   <= '0;
			prod_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						len_q   <= len_in;
						rem_q   <= rem_in;
						prod_q  <= {{SQ_W{1'b0}}, delta};
						state_q <= U_DEN;
					end
				end
				U_DEN: begin
					den_q   <= sq;
					state_q <= U_RR;
				end
				U_RR: begin
					num_q   <= sq;
					state_q <= U_NUM;
				end
				U_NUM: begin
					num_q   <= den_q - num_q;
					cnt_q   <= CNT_W'(COUNT_BITS - 1);
					state_q <= U_MUL;
				end
				U_MUL: begin
					prod_q <= {acc_sum[SQ_W:0], lo[COUNT_BITS-1:1]};
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(COUNT_BITS - 1);
						state_q <= U_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_DIV: begin
					prod_q <= {(ge ? acc_sum[SQ_W-1:0] : acc_a[SQ_W-1:0]),
					           lo[COUNT_BITS-2:0], ge};
					if (cnt_q == '0) begin
						state_q <= U_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_DONE: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign quotient       = lo;
	assign status.done    = (state_q == U_DONE);
	assign status.inexact = |hi;

endmodule

[rtl/ercd_bcd.sv]
// Shift-add-3 binary to BCD, one bit per cycle. Low four digits kept;
// carries only move upward, so the kept digits are exact modulo 10^4.
module ercd_bcd #(
	parameter int VALUE_W = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_W-1:0]            value,
	output ercd_pkg::bcd_digits_t         digits,
	output logic                          done
);
	import ercd_pkg::*;

	localparam int BCD_W = 4 * DIGIT_W;
	localparam int CNT_W = $clog2(VALUE_W);

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} bstate_t;

	bstate_t          state_q;
	logic [VALUE_W-1:0] shift_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		logic [DIGIT_W-1:0] d;
		adj = bcd_q;
		for (int k = 0; k < 4; k++) begin
			d = bcd_q[k*DIGIT_W +: DIGIT_W];
			adj[k*DIGIT_W +: DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			shift_q <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						shift_q <= value;
						bcd_q   <= '0;
						cnt_q   <= CNT_W'(VALUE_W - 1);
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					bcd_q   <= {adj[BCD_W-2:0], shift_q[VALUE_W-1]};
					shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= B_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				B_DONE: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign digits = bcd_q;
	assign done   = (state_q == B_DONE);

endmodule

[rtl/eased_rollup_counter_display_core.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall    in_item  (time_step, observed_count)
// out       output     out_valid / out_stall  out_item (shown count, digits, blanks, glow)
// cfg       input      cfg_wen                cfg_index, cfg_data
//
// One tick at a time. A tick that advances a running catch-up goes through the
// shared multiply/divide unit (setup states, COUNT_BITS multiply steps, COUNT_BITS
// divide steps and a done state), then through the OW-step binary to BCD
// converter. Other ticks go through the converter only. OW is the wider of
// COUNT_BITS and the 16-bit field.
// Reset clears the animation state and loads the register defaults.
// The result sits in an output register; the next tick is taken while it waits,
// and the block only holds before loading a new result while out_stall is high.
module eased_rollup_counter_display_core #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  ercd_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output ercd_pkg::out_item_t              out_item,
	input  logic                             cfg_wen,
	input  logic [ercd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ercd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ercd_pkg::*;

	// widest of the time field and the time state
	localparam int WW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
	// widest of the count field and the count state
	localparam int OW = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

	localparam logic [OW-1:0] DEC_10   = OW'(10);
	localparam logic [OW-1:0] DEC_100  = OW'(100);
	localparam logic [OW-1:0] DEC_1000 = OW'(1000);

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_MATH, S_DISP, S_BCD, S_OUT} state_t;

	state_t                state_q;

	// configuration
	logic [FIELD_W-1:0]    len_q;
	logic                  rev_q;
	logic [FIELD_W-1:0]    init_q;

	// animation state
	logic [TIME_BITS-1:0]  rem_q;
	logic [COUNT_BITS-1:0] shown_q;
	logic [COUNT_BITS-1:0] start_q;
	logic [COUNT_BITS-1:0] target_q;

	logic [OW-1:0]         disp_q;
	logic                  out_valid_q;
	out_item_t             out_item_q;

	logic                  in_xfer;
	logic [WW-1:0]         len_ext;
	logic [WW-1:0]         tmax_ext;
	logic [TIME_BITS-1:0]  tl;
	logic [WW-1:0]         step_ext;
	logic                  snap;
	logic [TIME_BITS-1:0]  rem_dec;
	logic [COUNT_BITS-1:0] obs;

	logic                  up;
	logic [TIME_BITS-1:0]  r_eff;
	logic [COUNT_BITS-1:0] delta;
	logic [COUNT_BITS-1:0] quotient;
	muldiv_status_t        mstat;
	logic [COUNT_BITS-1:0] eased_up;
	logic [COUNT_BITS-1:0] eased_down;

	logic [OW-1:0]         shown_w;
	logic [OW-1:0]         init_w;
	logic [OW-1:0]         disp_c;
	bcd_digits_t           digits;
	logic                  bcd_done;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// effective catch-up length: zero acts as one, saturate to the time range
	assign len_ext  = WW'(len_q);
	assign tmax_ext = WW'({TIME_BITS{1'b1}});
	assign tl = (len_q == '0)         ? TIME_BITS'(1) :
	            (len_ext > tmax_ext)  ? tmax_ext[TIME_BITS-1:0] :
	                                    len_ext[TIME_BITS-1:0];

	// remaining-time update; on no snap the step is below rem and fits
	assign step_ext = WW'(in_item.time_step);
	assign snap     = (step_ext >= WW'(rem_q));
	assign rem_dec  = rem_q - step_ext[TIME_BITS-1:0];
	assign obs      = COUNT_BITS'(in_item.observed_count);

	// easing operands, sampled by the unit on the prep cycle
	assign up    = (target_q >= start_q);
	assign delta = up ? (target_q - start_q) : (start_q - target_q);
	// a length shrunk mid-run caps r at T, so the shown value stays at start
	assign r_eff = (rem_q > tl) ? tl : rem_q;

	ercd_muldiv #(
		.COUNT_BITS (COUNT_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_PREP),
		.len_in   (tl),
		.rem_in   (r_eff),
		.delta    (delta),
		.quotient (quotient),
		.status   (mstat)
	);

	// rounding up toward the target, truncating when counting down
	assign eased_up   = start_q + quotient + COUNT_BITS'(mstat.inexact);
	assign eased_down = start_q - quotient;

	// display value: shown, or initial minus shown clamped at zero
	assign shown_w = OW'(shown_q);
	assign init_w  = OW'(init_q);
	assign disp_c  = rev_q ? ((init_w > shown_w) ? (init_w - shown_w) : '0) : shown_w;

	ercd_bcd #(
		.VALUE_W (OW)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DISP),
		.value  (disp_c),
		.digits (digits),
		.done   (bcd_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= LENGTH_RESET;
			rev_q       <= 1'b0;
			init_q      <= '0;
			rem_q       <= '0;
			shown_q     <= '0;
			start_q     <= '0;
			target_q    <= '0;
			disp_q      <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_CATCH_UP_LENGTH: len_q  <= cfg_data;
					REG_REVERSED_MODE:   rev_q  <= cfg_data[0];
					REG_INITIAL_VALUE:   init_q <= cfg_data;
					default: ;
				endcase
			end

			// in the output state a new result may take the freed slot instead
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (rem_q != '0) begin
							if (snap) begin
								// end of run, exact zero included
								rem_q   <= '0;
								shown_q <= target_q;
								start_q <= target_q;
								state_q <= S_DISP;
							end else begin
								rem_q   <= rem_dec;
								state_q <= S_PREP;
							end
						end else begin
							// count changes only start a run when none is going
							if (obs != shown_q) begin
								rem_q    <= tl;
								target_q <= obs;
							end
							state_q <= S_DISP;
						end
					end
				end
				S_PREP: begin
					state_q <= S_MATH;
				end
				S_MATH: begin
					if (mstat.done) begin
						shown_q <= up ? eased_up : eased_down;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					disp_q  <= disp_c;
					state_q <= S_BCD;
				end
				S_BCD: begin
					if (bcd_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q                <= 1'b1;
						out_item_q.shown_count     <= FIELD_W'(shown_q);
						out_item_q.digit_thousands <= digits.thousands;
						out_item_q.digit_hundreds  <= digits.hundreds;
						out_item_q.digit_tens      <= digits.tens;
						out_item_q.digit_units     <= digits.units;
						out_item_q.blank_thousands <= (disp_q < DEC_1000);
						out_item_q.blank_hundreds  <= (disp_q < DEC_100);
						out_item_q.blank_tens      <= (disp_q < DEC_10);
						out_item_q.catching_up     <= (rem_q != '0);
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a tick transfer always blocks the input until its result is loaded
	a_stall_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after a tick transfer");

	// with no run going, shown, start and target agree
	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == '0) |-> (shown_q == start_q && target_q == start_q))
		else $error("idle animation state inconsistent");

	// the shown value never leaves the span from start to target
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		up ? (shown_q >= start_q && shown_q <= target_q)
		   : (shown_q <= start_q && shown_q >= target_q))
		else $error("shown value outside catch-up span");

	// the easing unit only finishes while the sequencer waits on it
	a_math_done: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |-> (state_q == S_MATH))
		else $error("easing unit done outside math state");

endmodule
